// ===== rtl/core/jch_pkg.sv =====
package jch_pkg;

   // Field and datapath widths.
   localparam int BUCKET_BITS = 16;
   localparam int KEY_W       = 64;
   localparam int HALF_W      = KEY_W / 2;
   localparam int JUMP_SHIFT  = 31;
   localparam int KEY_SHIFT   = 33;
   // Divisor is (key >> KEY_SHIFT) + 1, which needs one bit more than the shifted key.
   localparam int DEN_W       = KEY_W - KEY_SHIFT + 1;
   // Dividend is (b + 1) << JUMP_SHIFT, and b + 1 always fits in BUCKET_BITS.
   localparam int NUM_W       = BUCKET_BITS + JUMP_SHIFT;
   localparam int CNT_W       = $clog2(NUM_W);

   localparam logic [KEY_W-1:0]  LCG_MULT = 64'd2862933555777941757;
   localparam logic [HALF_W-1:0] LCG_LO   = LCG_MULT[HALF_W-1:0];
   localparam logic [HALF_W-1:0] LCG_HI   = LCG_MULT[KEY_W-1:HALF_W];

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_FINISH
   } step_type;

   typedef enum logic [1:0] {
      C_REQ_VALID,
      C_CAND_GE_N,
      C_DIV_MORE,
      C_OUT_FULL
   } cond_type;

   typedef enum logic [1:0] {
      G_ALWAYS,
      G_IF_TRUE,
      G_IF_FALSE
   } gate_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_TAKE_B,
      OP_MUL0,
      OP_MUL1,
      OP_MUL2,
      OP_MUL3,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_EMIT
   } op_type;

   typedef struct packed {
      cond_type cond;
      step_type next_t;
      step_type next_f;
      gate_type gate;
      op_type   op;
      logic     req_ready;
   } ucode_type;

   typedef struct packed {
      op_type op;
      logic   req_ready;
   } ctl_type;

   typedef struct packed {
      logic req_valid;
      logic cand_ge_n;
      logic div_more;
      logic out_full;
   } stat_type;

   // Control store: one word per step, with a branch on one status condition.
   function automatic ucode_type ucode_rom(step_type step);
      ucode_type uw;
      case (step)
         ST_IDLE:     uw = '{C_REQ_VALID, ST_CHECK, ST_IDLE, G_IF_TRUE, OP_LOAD, 1'b1};
         ST_CHECK:    uw = '{C_CAND_GE_N, ST_FINISH, ST_MUL0, G_IF_FALSE, OP_TAKE_B, 1'b0};
         ST_MUL0:     uw = '{C_REQ_VALID, ST_MUL1, ST_MUL1, G_ALWAYS, OP_MUL0, 1'b0};
         ST_MUL1:     uw = '{C_REQ_VALID, ST_MUL2, ST_MUL2, G_ALWAYS, OP_MUL1, 1'b0};
         ST_MUL2:     uw = '{C_REQ_VALID, ST_MUL3, ST_MUL3, G_ALWAYS, OP_MUL2, 1'b0};
         ST_MUL3:     uw = '{C_REQ_VALID, ST_DIV_INIT, ST_DIV_INIT, G_ALWAYS, OP_MUL3, 1'b0};
         ST_DIV_INIT: uw = '{C_REQ_VALID, ST_DIV_STEP, ST_DIV_STEP, G_ALWAYS, OP_DIV_INIT,
                             1'b0};
         ST_DIV_STEP: uw = '{C_DIV_MORE, ST_DIV_STEP, ST_CHECK, G_ALWAYS, OP_DIV_STEP, 1'b0};
         ST_FINISH:   uw = '{C_OUT_FULL, ST_FINISH, ST_IDLE, G_IF_FALSE, OP_EMIT, 1'b0};
         default:     uw = '{C_REQ_VALID, ST_IDLE, ST_IDLE, G_ALWAYS, OP_NONE, 1'b0};
      endcase
      return uw;
   endfunction

endpackage

// ===== rtl/core/jch_req_if.sv =====
interface jch_req_if import jch_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [KEY_W-1:0]       key;
   logic [BUCKET_BITS-1:0] bucket_count;

   modport source (output valid, output key, output bucket_count, input ready);
   modport sink (input valid, input key, input bucket_count, output ready);
endinterface

// ===== rtl/core/jch_rsp_if.sv =====
interface jch_rsp_if import jch_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [BUCKET_BITS-1:0] bucket;
   logic                   empty_res;

   modport source (output valid, output bucket, output empty_res, input ready);
   modport sink (input valid, input bucket, input empty_res, output ready);
endinterface

// ===== rtl/core/jch_seq.sv =====
module jch_seq import jch_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output ctl_type  ctl
);

   step_type  pc_ff, pc_in;
   ucode_type uw;
   logic      cond_val;
   logic      fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   always_comb begin
      uw = ucode_rom(pc_ff);
      case (uw.cond)
         C_REQ_VALID: cond_val = stat.req_valid;
         C_CAND_GE_N: cond_val = stat.cand_ge_n;
         C_DIV_MORE:  cond_val = stat.div_more;
         C_OUT_FULL:  cond_val = stat.out_full;
         default:     cond_val = 1'b0;
      endcase
      case (uw.gate)
         G_ALWAYS:   fire = 1'b1;
         G_IF_TRUE:  fire = cond_val;
         G_IF_FALSE: fire = !cond_val;
         default:    fire = 1'b0;
      endcase
      pc_in         = cond_val ? uw.next_t : uw.next_f;
      ctl.op        = fire ? uw.op : OP_NONE;
      ctl.req_ready = uw.req_ready;
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      pc_ff == ST_IDLE && stat.req_valid |=> pc_ff == ST_CHECK)
      else $error("accepted request did not start the search");

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      pc_ff == ST_DIV_STEP && !stat.div_more |=> pc_ff == ST_CHECK)
      else $error("divider exit did not return to the bound check");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_EMIT |-> !stat.out_full)
      else $error("result written over a pending transfer");

endmodule

// ===== rtl/core/jch_dp.sv =====
module jch_dp import jch_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  ctl_type                ctl,
   input  logic [KEY_W-1:0]       in_key,
   input  logic [BUCKET_BITS-1:0] in_count,
   output logic                   cand_ge_n,
   output logic                   div_more,
   output logic [BUCKET_BITS-1:0] bucket,
   output logic                   empty
);

   logic [KEY_W-1:0]       key_ff, key_in;
   logic [KEY_W-1:0]       acc_ff, acc_in;
   logic [KEY_W-1:0]       prod_ff, prod_in;
   logic [KEY_W-1:0]       prod_hi;
   logic [HALF_W-1:0]      mul_a, mul_b;
   logic [BUCKET_BITS-1:0] n_ff, n_in;
   logic [BUCKET_BITS-1:0] b_ff, b_in;
   logic [BUCKET_BITS-1:0] b_plus;
   logic [NUM_W-1:0]       quot_ff, quot_in;
   logic [DEN_W-1:0]       den_ff, den_in;
   logic [DEN_W-1:0]       rem_ff, rem_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [DEN_W:0]         rem_shift, rem_diff;

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      n_ff    <= n_in;
      b_ff    <= b_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   always_comb begin
      // The one 32x32 multiplier; the LCG multiply is three partial products.
      mul_a     = (ctl.op == OP_MUL1) ? key_ff[KEY_W-1:HALF_W] : key_ff[HALF_W-1:0];
      mul_b     = (ctl.op == OP_MUL2) ? LCG_HI : LCG_LO;
      prod_hi   = {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
      b_plus    = b_ff + BUCKET_BITS'(1);
      rem_shift = {rem_ff, quot_ff[NUM_W-1]};
      rem_diff  = rem_shift - {1'b0, den_ff};

      key_in  = key_ff;
      acc_in  = acc_ff;
      prod_in = KEY_W'(mul_a * mul_b);
      n_in    = n_ff;
      b_in    = b_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;

      case (ctl.op)
         OP_LOAD: begin
            key_in  = in_key;
            n_in    = in_count;
            b_in    = '0;
            quot_in = '0;
         end
         OP_TAKE_B: begin
            b_in = quot_ff[BUCKET_BITS-1:0];
         end
         OP_MUL1: begin
            acc_in = prod_ff;
         end
         OP_MUL2: begin
            acc_in = acc_ff + prod_hi;
         end
         OP_MUL3: begin
            key_in = acc_ff + prod_hi + KEY_W'(1);
         end
         OP_DIV_INIT: begin
            quot_in = {b_plus, {JUMP_SHIFT{1'b0}}};
            den_in  = {1'b0, key_ff[KEY_W-1:KEY_SHIFT]} + DEN_W'(1);
            rem_in  = '0;
            cnt_in  = CNT_W'(NUM_W - 1);
         end
         OP_DIV_STEP: begin
            if (!rem_diff[DEN_W]) begin
               rem_in  = rem_diff[DEN_W-1:0];
               quot_in = {quot_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift[DEN_W-1:0];
               quot_in = {quot_ff[NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   assign cand_ge_n = quot_ff >= NUM_W'(n_ff);
   assign div_more  = cnt_ff != '0;
   assign bucket    = b_ff;
   assign empty     = n_ff == '0;

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_DIV_INIT |=> den_ff != '0)
      else $error("divisor loaded as zero");

   a_bucket_bound: assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_EMIT && n_ff != '0 |-> b_ff < n_ff)
      else $error("chosen bucket outside the bucket count");

endmodule

// ===== rtl/core/jump_consistent_hash.sv =====
// Jump consistent hash bucket selector. A request transfer carries a 64-bit
// key and a bucket count; one response transfer returns the bucket that jump
// consistent hashing assigns to that key, or sets empty_res (with bucket 0)
// when the bucket count is zero. The search is run by a small microcoded
// sequencer over one datapath: each round advances the key with a 64-bit
// linear congruential step built from three 32x32 partial products, then
// forms the next jump as an exact integer quotient in a restoring divider
// that retires one quotient bit per cycle. The number of rounds per request
// is zero for an empty count, about ln(bucket_count) + 1 on average and at
// most bucket_count; each round runs the multiply steps MUL0 to MUL3, a
// divider load, one divider step per dividend bit (BUCKET_BITS + 31 = 47
// bits) and a bound check. A finished result sits in the output register,
// so the next request is accepted while the previous response still waits
// to be taken.
module jump_consistent_hash import jch_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   jch_req_if.sink   req_ch,
   jch_rsp_if.source rsp_ch
);

   ctl_type                ctl;
   stat_type               stat;
   logic                   cand_ge_n;
   logic                   div_more;
   logic [BUCKET_BITS-1:0] dp_bucket;
   logic                   dp_empty;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BUCKET_BITS-1:0] rsp_bucket_ff, rsp_bucket_in;
   logic                   rsp_empty_ff, rsp_empty_in;

   // The output slot counts as full only if it holds a result that is not
   // leaving in this cycle.
   assign stat.req_valid = req_ch.valid;
   assign stat.cand_ge_n = cand_ge_n;
   assign stat.div_more  = div_more;
   assign stat.out_full  = rsp_valid_ff && !rsp_ch.ready;

   assign req_ch.ready = ctl.req_ready;

   jch_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   jch_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .in_key    (req_ch.key),
      .in_count  (req_ch.bucket_count),
      .cand_ge_n (cand_ge_n),
      .div_more  (div_more),
      .bucket    (dp_bucket),
      .empty     (dp_empty)
   );

   // Output register: loaded when the sequencer emits, cleared by a transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_bucket_in = rsp_bucket_ff;
      rsp_empty_in  = rsp_empty_ff;
      if (ctl.op == OP_EMIT) begin
         rsp_valid_in  = 1'b1;
         rsp_bucket_in = dp_bucket;
         rsp_empty_in  = dp_empty;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.bucket    = rsp_bucket_ff;
   assign rsp_ch.empty_res = rsp_empty_ff;

endmodule
